FILE: src/iirl_pkg.sv
// ----------------------------------------------------------------------------
// iirl_pkg
// Shared types and constants for the indexed insert/remove list: operation
// and status codes, default sizes, fixed port widths and the cell controls.
// ----------------------------------------------------------------------------
`default_nettype none

package iirl_pkg;

    // Default sizes for the top-level parameters
    localparam int DEPTH_DEF      = 16;
    localparam int ELEM_WIDTH_DEF = 32;

    // Fixed port widths
    localparam int POS_W     = 5;
    localparam int DATA_W    = 32;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // Per-cycle shift controls broadcast to every cell
    typedef struct packed {
        logic ins;   // open a slot at ins_pos, shift later cells up
        logic rem;   // close the slot at the read index, shift later cells down
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/iirl_cell.sv
// ----------------------------------------------------------------------------
// iirl_cell
// One storage cell of the list. Holds one element, takes a new value or a
// neighbor's value on insert/remove, and drives its element onto the read
// tap when its index is selected.
// ----------------------------------------------------------------------------
`default_nettype none

module iirl_cell
    import iirl_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int INDEX      = 0
)
(
    input  wire logic                         clk,
    input  wire cell_ctrl_t                   ctrl,
    input  wire logic [$clog2(DEPTH+1)-1:0]   ins_pos,
    input  wire logic [$clog2(DEPTH)-1:0]     rd_idx,
    input  wire logic [ELEM_WIDTH-1:0]        new_elem,
    input  wire logic [ELEM_WIDTH-1:0]        left_elem,
    input  wire logic [ELEM_WIDTH-1:0]        right_elem,
    output logic      [ELEM_WIDTH-1:0]        elem,
    output logic      [ELEM_WIDTH-1:0]        tap
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam logic [CW-1:0] MY_POS = CW'(INDEX);
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [ELEM_WIDTH-1:0] data_reg;
    logic [ELEM_WIDTH-1:0] data_next;

    // Pick the next value: new element, left neighbor, right neighbor or hold
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ins)
        begin
            if (MY_POS == ins_pos)
                data_next = new_elem;
            else if (MY_POS > ins_pos)
                data_next = left_elem;
        end
        else if (ctrl.rem)
        begin
            if (MY_IDX >= rd_idx)
                data_next = right_elem;
        end
    end

    // Hold the element
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign elem = data_reg;

    // Drive the read tap only when selected
    assign tap = (rd_idx == MY_IDX) ? data_reg : '0;

endmodule

`default_nettype wire

FILE: src/indexed_insert_remove_list.sv
// ----------------------------------------------------------------------------
// indexed_insert_remove_list
// Fixed-capacity ordered list with push, pop, insert-at-index and
// remove-at-index, built as a chain of cells that all shift at once.
// ----------------------------------------------------------------------------
//
//  channel | signals                                     | accepted when
//  --------+---------------------------------------------+-----------------------
//  in      | operation, position, element_in             | in_valid && !in_stall
//  out     | element_out, status, count_after            | out_valid && !out_stall
//
// The whole cell chain shifts by one place in the accepting cycle and the
// response lands in the output register on the same edge, so one request
// per cycle is sustained while out_stall is low.
// in_stall is high only while a response waits in the output register and
// out_stall holds it. Reset clears the count and the output valid; the cell
// contents are not reset and only cells below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_insert_remove_list
    import iirl_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           operation,
    input  wire logic [POS_W-1:0]     position,
    input  wire logic [DATA_W-1:0]    element_in,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic      [DATA_W-1:0]    element_out,
    output logic      [1:0]           status,
    output logic      [CNT_OUT_W-1:0] count_after
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IW  = $clog2(DEPTH);
    localparam int PW  = (CW > POS_W) ? CW : POS_W;
    localparam int EXW = (ELEM_WIDTH > DATA_W) ? ELEM_WIDTH : DATA_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [CW-1:0]          cnt_reg;
    logic [CW-1:0]          cnt_next;
    logic                   out_valid_reg;
    logic [DATA_W-1:0]      elem_out_reg;
    status_t                status_reg;
    logic [CNT_OUT_W-1:0]   cnt_out_reg;

    logic                   accept;
    op_t                    op;
    logic [PW-1:0]          pos_x;
    logic [PW-1:0]          cnt_x;
    logic [CW-1:0]          cnt_dec;
    logic [EXW-1:0]         val_wide;
    logic [ELEM_WIDTH-1:0]  new_val;
    cell_ctrl_t             ctrl;
    cell_ctrl_t             ctrl_req;
    logic [CW-1:0]          ins_pos;
    logic [IW-1:0]          rd_idx;
    logic                   take;
    status_t                status_next;
    logic [ELEM_WIDTH-1:0]  taken;
    logic [EXW-1:0]         taken_wide;
    logic [DATA_W-1:0]      elem_out_next;
    logic [PW-1:0]          cnt_next_x;

    logic [ELEM_WIDTH-1:0]  cell_elem [DEPTH];
    logic [ELEM_WIDTH-1:0]  cell_tap  [DEPTH];

    // Handshake
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign op       = op_t'(operation);
    assign pos_x    = PW'(position);
    assign cnt_x    = PW'(cnt_reg);
    assign cnt_dec  = cnt_reg - CW'(1);
    assign val_wide = EXW'(element_in);
    assign new_val  = val_wide[ELEM_WIDTH-1:0];

    // Decode the operation, check bounds and pick shift controls
    always_comb
    begin
        status_next  = ST_OK;
        ctrl_req.ins = 1'b0;
        ctrl_req.rem = 1'b0;
        ins_pos      = pos_x[CW-1:0];
        rd_idx       = pos_x[IW-1:0];
        take         = 1'b0;
        cnt_next     = cnt_reg;
        unique case (op)
            OP_PUSH:
            begin
                if (cnt_reg == FULL_CNT)
                    status_next = ST_FULL;
                else
                begin
                    ctrl_req.ins = 1'b1;
                    ins_pos      = cnt_reg;
                    cnt_next     = cnt_reg + CW'(1);
                end
            end
            OP_POP:
            begin
                rd_idx = cnt_dec[IW-1:0];
                if (cnt_reg == '0)
                    status_next = ST_EMPTY;
                else
                begin
                    take     = 1'b1;
                    cnt_next = cnt_dec;
                end
            end
            OP_INSERT:
            begin
                if (pos_x > cnt_x)
                    status_next = ST_RANGE;
                else if (cnt_reg == FULL_CNT)
                    status_next = ST_FULL;
                else
                begin
                    ctrl_req.ins = 1'b1;
                    cnt_next     = cnt_reg + CW'(1);
                end
            end
            OP_REMOVE:
            begin
                if (pos_x >= cnt_x)
                    status_next = ST_RANGE;
                else
                begin
                    ctrl_req.rem = 1'b1;
                    take         = 1'b1;
                    cnt_next     = cnt_dec;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Shift only on an accepted request
    assign ctrl.ins = accept && ctrl_req.ins;
    assign ctrl.rem = accept && ctrl_req.rem;

    // Cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ELEM_WIDTH-1:0] left_w;
        logic [ELEM_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = new_val;
        end
        else
        begin : g_mid_l
            assign left_w = cell_elem[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = cell_elem[i];
        end
        else
        begin : g_mid_r
            assign right_w = cell_elem[i+1];
        end

        iirl_cell #(
            .DEPTH      (DEPTH),
            .ELEM_WIDTH (ELEM_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .ins_pos    (ins_pos),
            .rd_idx     (rd_idx),
            .new_elem   (new_val),
            .left_elem  (left_w),
            .right_elem (right_w),
            .elem       (cell_elem[i]),
            .tap        (cell_tap[i])
        );
    end

    // Merge the read taps; only the selected cell drives a nonzero value
    always_comb
    begin
        taken = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            taken = taken | cell_tap[i];
        end
    end

    assign taken_wide    = EXW'(taken);
    assign elem_out_next = take ? taken_wide[DATA_W-1:0] : '0;
    assign cnt_next_x    = PW'(cnt_next);

    // Advance the element count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (accept)
            cnt_reg <= cnt_next;
    end

    // Output valid: set on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            elem_out_reg <= elem_out_next;
            status_reg   <= status_next;
            cnt_out_reg  <= cnt_next_x[CNT_OUT_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign element_out = elem_out_reg;
    assign status      = status_reg;
    assign count_after = cnt_out_reg;

    // Count never exceeds the capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FULL_CNT)
        else $error("element count above capacity");

    // A failed request leaves the count unchanged
    a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status_next != ST_OK |=> cnt_reg == $past(cnt_reg))
        else $error("failed request changed the count");

    // A failed response carries a zero element
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> element_out == '0)
        else $error("nonzero element on failed response");

    // Input stalls only behind a held response
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held response");

endmodule

`default_nettype wire

FILE: test/indexed_insert_remove_list_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_chk
// Passive checker for the indexed insert/remove list. It keeps a shadow copy
// of the list, works out the response that each accepted request must give,
// and compares each accepted response with the oldest one still owed.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_chk
    import iirl_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic [1:0]           operation,
    input  wire logic [POS_W-1:0]     position,
    input  wire logic [DATA_W-1:0]    element_in,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic [DATA_W-1:0]    element_out,
    input  wire logic [1:0]           status,
    input  wire logic [CNT_OUT_W-1:0] count_after,
    output int                        fail_count,
    output int                        pending
);

    typedef struct {
        logic [DATA_W-1:0]    element;
        status_t              code;
        logic [CNT_OUT_W-1:0] length;
    } list_result_t;

    logic [DATA_W-1:0] shadow_cells [DEPTH_DEF];
    int                shadow_len = 0;
    list_result_t      owed_responses [$];
    int                mismatches = 0;
    int                owed_count = 0;

    assign fail_count = mismatches;
    assign pending    = owed_count;

    // Apply one request to the shadow list and return the response it gives
    function automatic list_result_t apply_list_op(input op_t op, input int pos,
                                                   input logic [DATA_W-1:0] value);
        list_result_t res;
        res.element = '0;
        res.code    = ST_OK;
        case (op)
            OP_PUSH:
            begin
                if (shadow_len >= DEPTH_DEF)
                    res.code = ST_FULL;
                else
                begin
                    shadow_cells[shadow_len] = value;
                    shadow_len++;
                end
            end
            OP_POP:
            begin
                if (shadow_len == 0)
                    res.code = ST_EMPTY;
                else
                begin
                    shadow_len--;
                    res.element = shadow_cells[shadow_len];
                end
            end
            OP_INSERT:
            begin
                // range check wins over the full check
                if (pos > shadow_len)
                    res.code = ST_RANGE;
                else if (shadow_len >= DEPTH_DEF)
                    res.code = ST_FULL;
                else
                begin
                    for (int i = shadow_len; i > pos; i--)
                        shadow_cells[i] = shadow_cells[i - 1];
                    shadow_cells[pos] = value;
                    shadow_len++;
                end
            end
            default:
            begin
                if (pos >= shadow_len)
                    res.code = ST_RANGE;
                else
                begin
                    res.element = shadow_cells[pos];
                    for (int i = pos; i + 1 < shadow_len; i++)
                        shadow_cells[i] = shadow_cells[i + 1];
                    shadow_len--;
                end
            end
        endcase
        res.length = CNT_OUT_W'(shadow_len);
        return res;
    endfunction

    // Compare responses first, then record the request taken on this edge
    always @(posedge clk or negedge rst_n)
    begin : track
        list_result_t owed;
        if (!rst_n)
        begin
            shadow_len = 0;
            owed_responses.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_responses.size() == 0)
                begin
                    $error("response with no request outstanding: element_out %h", element_out);
                    mismatches++;
                end
                else
                begin
                    owed = owed_responses.pop_front();
                    if (element_out !== owed.element)
                    begin
                        $error("element_out: expected %h, actual %h", owed.element, element_out);
                        mismatches++;
                    end
                    if (status !== owed.code)
                    begin
                        $error("status: expected %0d, actual %0d", owed.code, status);
                        mismatches++;
                    end
                    if (count_after !== owed.length)
                    begin
                        $error("count_after: expected %0d, actual %0d", owed.length,
                               count_after);
                        mismatches++;
                    end
                end
            end
            if (in_valid && !in_stall)
                owed_responses.push_back(apply_list_op(op_t'(operation), int'(position),
                                                       element_in));
        end
        owed_count = owed_responses.size();
    end

endmodule

FILE: test/indexed_insert_remove_list_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_tb
// Drives push, pop, insert and remove requests into the list: a directed
// pass over the empty, full and out-of-range cases, then random bursts that
// swing the list between empty and full under changing idle patterns and
// one long output hold-off. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_tb;
    import iirl_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int DRAIN_CYCLES   = 10;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [1:0]           operation  = '0;
    logic [POS_W-1:0]     position   = '0;
    logic [DATA_W-1:0]    element_in = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [DATA_W-1:0]    element_out;
    logic [1:0]           status;
    logic [CNT_OUT_W-1:0] count_after;

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic holdoff_req   = 1'b0;
    logic holdoff_done  = 1'b0;
    int   fail_count;
    int   pending;
    int   cycle_count   = 0;

    indexed_insert_remove_list uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .position    (position),
        .element_in  (element_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .element_out (element_out),
        .status      (status),
        .count_after (count_after)
    );

    indexed_insert_remove_list_chk list_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .position    (position),
        .element_in  (element_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .element_out (element_out),
        .status      (status),
        .count_after (count_after),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Offer one request, idling first at random, and hold it until taken
    task automatic send_request(input op_t op, input int pos, input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        operation  <= op;
        position   <= POS_W'(pos);
        element_in <= value;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Element values with the all-zero and all-one corners mixed in
    function automatic logic [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(15);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return $urandom();
    endfunction

    // Walk through empty, partly filled and full list corners
    task automatic run_directed();
        send_request(OP_POP, 0, pick_value());
        send_request(OP_REMOVE, 0, pick_value());
        send_request(OP_INSERT, 1, pick_value());
        send_request(OP_INSERT, 0, 32'h1234_5678);
        send_request(OP_PUSH, 31, '1);
        send_request(OP_PUSH, 16, '0);
        // insert at the current length behaves as a push
        send_request(OP_INSERT, 3, 32'hA5A5_5A5A);
        send_request(OP_INSERT, 0, 32'h5A5A_A5A5);
        send_request(OP_REMOVE, 5, pick_value());
        send_request(OP_REMOVE, 2, pick_value());
        send_request(OP_POP, 7, pick_value());
        // fill up to capacity
        for (int k = 0; k < 13; k++)
            send_request(OP_PUSH, $urandom_range(16), pick_value());
        send_request(OP_PUSH, 0, pick_value());
        send_request(OP_INSERT, 5, pick_value());
        send_request(OP_INSERT, 16, pick_value());
        send_request(OP_REMOVE, 16, pick_value());
        send_request(OP_REMOVE, 15, pick_value());
        send_request(OP_REMOVE, 0, pick_value());
    endtask

    // Alternate growing and shrinking bursts so the list swings end to end
    task automatic run_random(input int n_items);
        int   burst_left;
        bit   growing;
        int   roll;
        op_t  op;
        int   pos;
        burst_left = 0;
        growing    = $urandom_range(1);
        for (int k = 0; k < n_items; k++)
        begin
            if (burst_left == 0)
            begin
                growing    = !growing;
                burst_left = $urandom_range(8, 40);
            end
            burst_left--;
            roll = $urandom_range(99);
            if (roll < 5)
                op = op_t'($urandom_range(3));
            else if (roll < 50)
                op = growing ? OP_PUSH : OP_POP;
            else if (roll < 90)
                op = growing ? OP_INSERT : OP_REMOVE;
            else
                op = growing ? OP_REMOVE : OP_INSERT;
            pos = ($urandom_range(9) < 7) ? $urandom_range(8) : $urandom_range(16);
            send_request(op, pos, pick_value());
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int held;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (holdoff_req && !holdoff_done)
            begin
                out_stall <= 1'b1;
                held++;
                if (held >= HOLDOFF_CYCLES)
                    holdoff_done = 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Stimulus and verdict
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 19;
        recv_idle_pct = 51;
        run_directed();
        run_random(600);

        send_idle_pct = 51;
        recv_idle_pct = 19;
        run_random(600);

        // no idling; hold the output long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(100);
        holdoff_req <= 1'b1;
        run_random(500);
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Timeout
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
